### src/mci_pkg.sv
package mci_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 16;
    localparam int OUT_W    = SAMPLE_W + 2;
    localparam int CFG_W    = 16;

    // datapath widths
    localparam int DIFF_W   = SAMPLE_W + 1;          // differences of two samples
    localparam int COEF_W   = SAMPLE_W + 4;          // c3, c2
    localparam int A_W      = SAMPLE_W + 6;          // Horner partial sums
    localparam int C3P_W    = COEF_W + POS_W + 1;    // c3 * pos
    localparam int PROD_W   = A_W + POS_W + 1;       // partial sum * pos
    localparam int SUM_W    = PROD_W + 1;            // final accumulator
    localparam int RES_W    = SUM_W - POS_W - 1;     // rounded value before clamp

    localparam int NSTG     = 8;

    localparam logic [CFG_W-1:0] FLAT_LIMIT_RESET = CFG_W'(1);

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< POS_W;
    localparam logic signed [RES_W-1:0] OUT_MAX    = RES_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [RES_W-1:0] OUT_MIN    = RES_W'(-(1 << (OUT_W - 1)));

endpackage

### src/monotone_cubic_interpolator_core.sv
// Monotone cubic interpolator. Each input word carries four neighboring
// signed samples and a Q0.16 position; the core returns the cubic Hermite
// value between sample_start (position 0) and sample_end (position 1),
// rounded to nearest (ties up) and clamped to 18 bits signed. End slopes are
// central differences; both are zeroed when |sample_end - sample_start| is
// below flat_limit, and each is zeroed on its own when its sign disagrees
// with the middle step. Throughput is one word per clock while result_stall
// is low; the datapath has eight register stages (sample differences, slope
// limiting, three Horner multiplies, the first two each with its add in the
// following stage, and the last add with round/clamp in the final stage).
// Each stage holds its word under result_stall and refills as soon as the
// stage after it frees up, so bubbles are squeezed out while the output
// waits. flat_limit resets to 1 and is written through the cfg channel,
// which is always ready; write it only while the core is empty.
module monotone_cubic_interpolator_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // config write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mci_pkg::CFG_W-1:0]            cfg_data,
    // sample channel
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic signed [mci_pkg::SAMPLE_W-1:0]  sample_before,
    input  logic signed [mci_pkg::SAMPLE_W-1:0]  sample_start,
    input  logic signed [mci_pkg::SAMPLE_W-1:0]  sample_end,
    input  logic signed [mci_pkg::SAMPLE_W-1:0]  sample_after,
    input  logic [mci_pkg::POS_W-1:0]            position,
    // result channel
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic signed [mci_pkg::OUT_W-1:0]     interpolated
);

    import mci_pkg::*;

    // ------------------------------------------------------------------
    // config register
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] flat_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flat_limit_reg <= FLAT_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            flat_limit_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: a stage loads when it is empty or its successor
    // loads; the last stage loads when the result is empty or taken
    // ------------------------------------------------------------------
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic [NSTG-1:0] stg_ready;

    always_comb
    begin
        stg_ready[NSTG-1] = !valid_reg[NSTG-1] || !result_stall;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            stg_ready[i] = !valid_reg[i] || stg_ready[i+1];
        end
        valid_next = valid_reg;
        if (stg_ready[0])
        begin
            valid_next[0] = sample_valid;
        end
        for (int i = 1; i < NSTG; i++)
        begin
            if (stg_ready[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign sample_stall = !stg_ready[0];
    assign result_valid = valid_reg[NSTG-1];

    // ------------------------------------------------------------------
    // payload registers (no reset)
    // ------------------------------------------------------------------
    // stage 0: differences
    logic signed [DIFF_W-1:0]   s1_reg, s2_reg, d_reg;
    logic signed [SAMPLE_W-1:0] p1_0_reg;
    logic [POS_W-1:0]           pos_0_reg;
    // stage 1: coefficients
    logic signed [COEF_W-1:0]   c3_reg, c2_1_reg;
    logic signed [DIFF_W-1:0]   c1_1_reg;
    logic signed [SAMPLE_W-1:0] p1_1_reg;
    logic [POS_W-1:0]           pos_1_reg;
    // stage 2: c3 * u
    logic signed [C3P_W-1:0]    m1_reg;
    logic signed [COEF_W-1:0]   c2_2_reg;
    logic signed [DIFF_W-1:0]   c1_2_reg;
    logic signed [SAMPLE_W-1:0] p1_2_reg;
    logic [POS_W-1:0]           pos_2_reg;
    // stage 3: first Horner sum
    logic signed [A_W-1:0]      a1_reg;
    logic signed [DIFF_W-1:0]   c1_3_reg;
    logic signed [SAMPLE_W-1:0] p1_3_reg;
    logic [POS_W-1:0]           pos_3_reg;
    // stage 4: a1 * u
    logic signed [PROD_W-1:0]   m2_reg;
    logic signed [DIFF_W-1:0]   c1_4_reg;
    logic signed [SAMPLE_W-1:0] p1_4_reg;
    logic [POS_W-1:0]           pos_4_reg;
    // stage 5: second Horner sum
    logic signed [A_W-1:0]      a2_reg;
    logic signed [SAMPLE_W-1:0] p1_5_reg;
    logic [POS_W-1:0]           pos_5_reg;
    // stage 6: a2 * pos
    logic signed [PROD_W-1:0]   m3_reg;
    logic signed [SAMPLE_W-1:0] p1_6_reg;
    // stage 7: result
    logic signed [OUT_W-1:0]    result_reg;

    // ------------------------------------------------------------------
    // stage 0 logic: slopes in half units and middle step
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] s1_next, s2_next, d_next;

    always_comb
    begin
        s1_next = {sample_end[SAMPLE_W-1], sample_end}
                - {sample_before[SAMPLE_W-1], sample_before};
        s2_next = {sample_after[SAMPLE_W-1], sample_after}
                - {sample_start[SAMPLE_W-1], sample_start};
        d_next  = {sample_end[SAMPLE_W-1], sample_end}
                - {sample_start[SAMPLE_W-1], sample_start};
    end

    // ------------------------------------------------------------------
    // stage 1 logic: slope limiting and cubic coefficients
    // ------------------------------------------------------------------
    logic [DIFF_W-1:0]        d_mag;
    logic                     flat;
    logic                     keep1, keep2;
    logic signed [DIFF_W-1:0] s1_lim, s2_lim;
    logic signed [COEF_W-1:0] s1_ext, s2_ext, d_ext;
    logic signed [COEF_W-1:0] c3_next, c2_next;

    always_comb
    begin
        d_mag = d_reg[DIFF_W-1] ? DIFF_W'(-d_reg) : DIFF_W'(d_reg);
        flat  = {{CFG_W{1'b0}}, d_mag} < {{DIFF_W{1'b0}}, flat_limit_reg};
        // sign agreement: same zero-ness and same sign bit
        keep1 = !flat && (s1_reg[DIFF_W-1] == d_reg[DIFF_W-1])
                      && ((s1_reg == '0) == (d_reg == '0));
        keep2 = !flat && (s2_reg[DIFF_W-1] == d_reg[DIFF_W-1])
                      && ((s2_reg == '0) == (d_reg == '0));
        s1_lim = keep1 ? s1_reg : '0;
        s2_lim = keep2 ? s2_reg : '0;
        s1_ext = COEF_W'(s1_lim);
        s2_ext = COEF_W'(s2_lim);
        d_ext  = COEF_W'(d_reg);
        c3_next = s1_ext + s2_ext - (d_ext <<< 2);
        c2_next = (d_ext <<< 2) + (d_ext <<< 1) - (s1_ext <<< 1) - s2_ext;
    end

    // ------------------------------------------------------------------
    // Horner and round/clamp logic
    // ------------------------------------------------------------------
    logic signed [POS_W:0]    u2, u4, u6;
    logic signed [C3P_W-1:0]  m1_next;
    logic signed [A_W-1:0]    a1_next, a2_next;
    logic signed [PROD_W-1:0] m2_next, m3_next;
    logic signed [SUM_W-1:0]  acc;
    logic signed [RES_W-1:0]  res;
    logic signed [OUT_W-1:0]  result_next;

    always_comb
    begin
        u2 = $signed({1'b0, pos_1_reg});
        u4 = $signed({1'b0, pos_3_reg});
        u6 = $signed({1'b0, pos_5_reg});
        m1_next = C3P_W'(c3_reg) * C3P_W'(u2);
        a1_next = A_W'(m1_reg >>> POS_W) + A_W'(c2_2_reg);
        m2_next = PROD_W'(a1_reg) * PROD_W'(u4);
        a2_next = A_W'(m2_reg >>> POS_W) + A_W'(c1_4_reg);
        m3_next = PROD_W'(a2_reg) * PROD_W'(u6);
        // c0 * 2^F with c0 = 2 * p1, plus half an output unit
        acc = SUM_W'(m3_reg) + (SUM_W'(p1_6_reg) <<< (POS_W + 1)) + ROUND_HALF;
        res = RES_W'(acc >>> (POS_W + 1));
        if (res > OUT_MAX)
        begin
            result_next = OUT_W'(OUT_MAX);
        end
        else if (res < OUT_MIN)
        begin
            result_next = OUT_W'(OUT_MIN);
        end
        else
        begin
            result_next = OUT_W'(res);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_ready[0])
        begin
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            d_reg     <= d_next;
            p1_0_reg  <= sample_start;
            pos_0_reg <= position;
        end
        if (stg_ready[1])
        begin
            c3_reg    <= c3_next;
            c2_1_reg  <= c2_next;
            c1_1_reg  <= s1_lim;
            p1_1_reg  <= p1_0_reg;
            pos_1_reg <= pos_0_reg;
        end
        if (stg_ready[2])
        begin
            m1_reg    <= m1_next;
            c2_2_reg  <= c2_1_reg;
            c1_2_reg  <= c1_1_reg;
            p1_2_reg  <= p1_1_reg;
            pos_2_reg <= pos_1_reg;
        end
        if (stg_ready[3])
        begin
            a1_reg    <= a1_next;
            c1_3_reg  <= c1_2_reg;
            p1_3_reg  <= p1_2_reg;
            pos_3_reg <= pos_2_reg;
        end
        if (stg_ready[4])
        begin
            m2_reg    <= m2_next;
            c1_4_reg  <= c1_3_reg;
            p1_4_reg  <= p1_3_reg;
            pos_4_reg <= pos_3_reg;
        end
        if (stg_ready[5])
        begin
            a2_reg    <= a2_next;
            p1_5_reg  <= p1_4_reg;
            pos_5_reg <= pos_4_reg;
        end
        if (stg_ready[6])
        begin
            m3_reg    <= m3_next;
            p1_6_reg  <= p1_5_reg;
        end
        if (stg_ready[7])
        begin
            result_reg <= result_next;
        end
    end

    assign interpolated = result_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // input only backs up when every stage holds a word
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (&valid_reg))
        else $error("input stalled with a free pipeline stage");

    // a zero middle step gives a flat cubic
    a_zero_step: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && stg_ready[1] && (d_reg == '0))
        |=> (c3_reg == '0) && (c2_1_reg == '0) && (c1_1_reg == '0))
        else $error("nonzero coefficient for zero step");

    // a held result word stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid && $stable(interpolated))
        else $error("result word changed under stall");

endmodule
